/* rtl/a2i64_pkg.sv */
// shared types, character codes and digit decode for the text-to-integer parser
`timescale 1ns / 1ps

package a2i64_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_BITS-1:0] RADIX_ONE   = 6'd1;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;

   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_X_LOW      = 8'h78;
   localparam logic [7:0] CH_X_UP       = 8'h58;
   localparam logic [7:0] CH_0          = 8'h30;
   localparam logic [7:0] CH_9          = 8'h39;
   localparam logic [7:0] CH_A_UP       = 8'h41;
   localparam logic [7:0] CH_Z_UP       = 8'h5A;
   localparam logic [7:0] CH_A_LOW      = 8'h61;
   localparam logic [7:0] CH_Z_LOW      = 8'h7A;
   localparam logic [7:0] CH_UPPER_BASE = 8'd55;
   localparam logic [7:0] CH_LOWER_BASE = 8'd87;

   localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd63;

   typedef enum logic [1:0] {
      PH_DONE,
      PH_BODY,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic                  negative;
      logic [RADIX_BITS-1:0] base;
      logic                  overflow;
      logic                  any_digit;
   } ctl_type;

   typedef struct packed {
      logic               valid;
      logic signed [63:0] value;
      logic               overflowed;
      logic               digits_seen;
   } result_type;

   function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [7:0] c);
      logic [DIGIT_BITS-1:0] d;
      if (c >= CH_0 && c <= CH_9) begin
         d = DIGIT_BITS'(c - CH_0);
      end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
         d = DIGIT_BITS'(c - CH_UPPER_BASE);
      end else if (c >= CH_A_LOW && c <= CH_Z_LOW) begin
         d = DIGIT_BITS'(c - CH_LOWER_BASE);
      end else begin
         d = DIGIT_NONE;
      end
      return d;
   endfunction

endpackage

/* rtl/a2i64_step.sv */
// one character step: prefix and sign handling, digit accumulate with saturation, result
`timescale 1ns / 1ps

module a2i64_step #(
   parameter int VALUE_BITS = a2i64_pkg::VALUE_BITS_DEFAULT
) (
   input  a2i64_pkg::ctl_type                ctl,
   input  logic [VALUE_BITS-1:0]             acc,
   input  logic [7:0]                        ch,
   input  logic                              first,
   input  logic [a2i64_pkg::RADIX_BITS-1:0]  radix,
   output a2i64_pkg::ctl_type                ctl_next,
   output logic [VALUE_BITS-1:0]             acc_next,
   output a2i64_pkg::result_type             result
);

   localparam int PW = VALUE_BITS + 7;
   localparam logic [PW-1:0] HALF = PW'(1) << (VALUE_BITS - 1);

   logic [a2i64_pkg::DIGIT_BITS-1:0] digit;
   logic                             radix_bad;
   logic                             is_sign;
   logic                             start_body;
   logic [a2i64_pkg::RADIX_BITS-1:0] sb_base;
   logic                             zero_prefix;
   logic                             x_prefix;
   logic [a2i64_pkg::RADIX_BITS-1:0] take_base;
   logic                             take;
   logic                             digit_ok;
   logic                             end_now;
   logic [VALUE_BITS-1:0]            acc_cur;
   logic                             neg_cur;
   logic                             ovf_cur;
   logic                             any_cur;
   logic [PW-1:0]                    limit;
   logic [PW-1:0]                    prod;
   logic                             over;
   logic [VALUE_BITS-1:0]            mag;

   assign digit     = a2i64_pkg::digit_of(ch);
   assign radix_bad = (radix == a2i64_pkg::RADIX_ONE) || (radix > a2i64_pkg::RADIX_MAX);
   assign is_sign   = first && !radix_bad
                    && (ch == a2i64_pkg::CH_MINUS || ch == a2i64_pkg::CH_PLUS);

   assign start_body = (first && !radix_bad && !is_sign)
                    || (!first && ctl.phase == a2i64_pkg::PH_BODY);
   assign sb_base    = first ? radix : ctl.base;
   assign zero_prefix = start_body && ch == a2i64_pkg::CH_0
                     && (sb_base == a2i64_pkg::RADIX_AUTO || sb_base == a2i64_pkg::BASE_HEX);
   assign x_prefix   = !first && ctl.phase == a2i64_pkg::PH_ZERO
                    && (ctl.base == a2i64_pkg::BASE_HEX || ctl.base == a2i64_pkg::BASE_OCT)
                    && (ch == a2i64_pkg::CH_X_LOW || ch == a2i64_pkg::CH_X_UP);

   always_comb begin
      if (start_body) begin
         take_base = (sb_base == a2i64_pkg::RADIX_AUTO) ? a2i64_pkg::BASE_DEC : sb_base;
      end else begin
         take_base = ctl.base;
      end
   end

   assign take = (start_body && !zero_prefix)
              || (!first && ctl.phase == a2i64_pkg::PH_DIGITS)
              || (!first && ctl.phase == a2i64_pkg::PH_ZERO && !x_prefix);

   // state as seen by this character (a first-flagged item starts clean)
   assign acc_cur = first ? '0 : acc;
   assign neg_cur = first ? (!radix_bad && ch == a2i64_pkg::CH_MINUS) : ctl.negative;
   assign ovf_cur = first ? 1'b0 : ctl.overflow;
   assign any_cur = first ? 1'b0 : ctl.any_digit;

   assign digit_ok = digit < take_base;
   assign end_now  = (first && radix_bad) || (take && !digit_ok);

   // acc * base + d > limit is the cutoff test without a divide
   assign limit = neg_cur ? HALF : HALF - PW'(1);
   assign prod  = PW'(acc_cur) * PW'(take_base) + PW'(digit);
   assign over  = prod > limit;

   // next phase and datapath next values
   always_comb begin
      if (end_now) begin
         ctl_next.phase = a2i64_pkg::PH_DONE;
      end else if (is_sign) begin
         ctl_next.phase = a2i64_pkg::PH_BODY;
      end else if (zero_prefix) begin
         ctl_next.phase = a2i64_pkg::PH_ZERO;
      end else if (x_prefix || take) begin
         ctl_next.phase = a2i64_pkg::PH_DIGITS;
      end else begin
         ctl_next.phase = ctl.phase;
      end
      ctl_next.negative  = neg_cur;
      ctl_next.base      = first ? radix : ctl.base;
      ctl_next.overflow  = ovf_cur;
      ctl_next.any_digit = any_cur;
      acc_next           = acc_cur;
      if (end_now) begin
         ctl_next.base = take ? take_base : ctl_next.base;
      end else if (zero_prefix) begin
         ctl_next.base      = (sb_base == a2i64_pkg::RADIX_AUTO) ? a2i64_pkg::BASE_OCT
                                                                : a2i64_pkg::BASE_HEX;
         ctl_next.any_digit = 1'b1;
         acc_next           = '0;
      end else if (x_prefix) begin
         ctl_next.base      = a2i64_pkg::BASE_HEX;
         ctl_next.any_digit = 1'b0;
         acc_next           = '0;
      end else if (take) begin
         ctl_next.base      = take_base;
         ctl_next.any_digit = 1'b1;
         if (!ovf_cur) begin
            if (over) begin
               ctl_next.overflow = 1'b1;
            end else begin
               acc_next = prod[VALUE_BITS-1:0];
            end
         end
      end
   end

   // result on the character that ends the number
   assign mag = ovf_cur ? limit[VALUE_BITS-1:0] : acc_cur;

   always_comb begin
      result.valid       = end_now;
      result.value       = neg_cur ? (64'(0) - 64'(mag)) : 64'(mag);
      result.overflowed  = ovf_cur;
      result.digits_seen = any_cur;
   end

endmodule

/* rtl/ascii_to_int64_radix_parser_top.sv */
// top level of the streaming text-to-integer parser: item registers, radix register, result register
`timescale 1ns / 1ps

// Takes one character per item and accepts a new item every clock cycle unless the input register
// is held because a waiting result is not taken. An accepted item lands in an input register, and
// once the result register can drain, one step (sign and prefix decode, then accumulator times
// base plus digit, compared against the signed limit) updates the parse state and, when the
// character ends the number, loads the result register. The radix register is sampled by the
// item that carries the first flag; write it only while the block is idle.
// The input side keeps moving while a result waits, as long as the result register can drain.

module ascii_to_int64_radix_parser_top #(
   parameter int VALUE_BITS = a2i64_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_ch,
   input  logic                             req_first,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [63:0]               rsp_value,
   output logic                             rsp_overflowed,
   output logic                             rsp_digits_seen,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [a2i64_pkg::RADIX_BITS-1:0] csr_radix
);

   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic [7:0]                       in_ch_ff;
   logic                             in_first_ff;
   logic [a2i64_pkg::RADIX_BITS-1:0] radix_ff;
   a2i64_pkg::ctl_type               ctl_ff;
   a2i64_pkg::ctl_type               ctl_in;
   logic [VALUE_BITS-1:0]            acc_ff;
   logic [VALUE_BITS-1:0]            acc_in;
   a2i64_pkg::result_type            step_result;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic signed [63:0]               rsp_value_ff;
   logic                             rsp_overflowed_ff;
   logic                             rsp_digits_seen_ff;
   logic                             proceed;
   logic                             req_take;

   assign proceed   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proceed;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (in_valid_ff && !proceed);
   assign rsp_valid_in = proceed ? step_result.valid : (rsp_valid_ff && !rsp_ready);

   a2i64_step #(
      .VALUE_BITS (VALUE_BITS)
   ) u_step (
      .ctl      (ctl_ff),
      .acc      (acc_ff),
      .ch       (in_ch_ff),
      .first    (in_first_ff),
      .radix    (radix_ff),
      .ctl_next (ctl_in),
      .acc_next (acc_in),
      .result   (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         radix_ff           <= a2i64_pkg::RADIX_RESET;
         ctl_ff.phase       <= a2i64_pkg::PH_DONE;
         ctl_ff.negative    <= 1'b0;
         ctl_ff.base        <= a2i64_pkg::BASE_DEC;
         ctl_ff.overflow    <= 1'b0;
         ctl_ff.any_digit   <= 1'b0;
         acc_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            radix_ff <= csr_radix;
         end
         if (proceed) begin
            ctl_ff <= ctl_in;
            acc_ff <= acc_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff    <= req_ch;
         in_first_ff <= req_first;
      end
      if (proceed && step_result.valid) begin
         rsp_value_ff       <= step_result.value;
         rsp_overflowed_ff  <= step_result.overflowed;
         rsp_digits_seen_ff <= step_result.digits_seen;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_overflowed  = rsp_overflowed_ff;
   assign rsp_digits_seen = rsp_digits_seen_ff;

endmodule
